// ===== sv/fdtd_room_reverb_top_defines.svh =====
// assertion macros for the fdtd room reverb block
// used by the top level only; needs clk and rst in scope
`ifndef FDTD_ROOM_REVERB_TOP_DEFINES_SVH
`define FDTD_ROOM_REVERB_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FRR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define FRR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/frr_pkg.sv =====
// shared types and constants of the fdtd room reverb block
// no dependencies
package frr_pkg;

  localparam int COEF_W = 18;
  localparam int IDX_W  = 10;
  localparam int SMP_W  = 24;
  localparam int CFG_INDEX_W = 8;

  // register indexes of the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_FACE_NB   = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FACE_PV   = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_EDGE_NB   = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_EDGE_PV   = 8'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_CORNER_NB = 8'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_CORNER_PV = 8'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE    = 8'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_LISTENER  = 8'd7;

  // reset values
  localparam logic signed [COEF_W-1:0] RST_FACE_NB   = 18'sd16177;
  localparam logic signed [COEF_W-1:0] RST_FACE_PV   = 18'sd63877;
  localparam logic signed [COEF_W-1:0] RST_EDGE_NB   = 18'sd15974;
  localparam logic signed [COEF_W-1:0] RST_EDGE_PV   = 18'sd62259;
  localparam logic signed [COEF_W-1:0] RST_CORNER_NB = 18'sd15777;
  localparam logic signed [COEF_W-1:0] RST_CORNER_PV = 18'sd60681;
  localparam logic [IDX_W-1:0] RST_SOURCE   = 10'd333;
  localparam logic [IDX_W-1:0] RST_LISTENER = 10'd775;

  // interior weights: 1/4 and 1 in Q2.16
  localparam logic signed [COEF_W-1:0] INT_NB = 18'sd16384;
  localparam logic signed [COEF_W-1:0] INT_PV = 18'sd65536;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INJ_RD,
    ST_INJ_WR,
    ST_READ,
    ST_MUL_N,
    ST_MUL_P,
    ST_WRITE,
    ST_OUT_RD,
    ST_OUT_LOAD
  } state_t;

  // stencil taps, read one per cycle from the current level
  typedef enum logic [2:0] {
    TAP_C,
    TAP_XL,
    TAP_XH,
    TAP_YL,
    TAP_YH,
    TAP_ZL,
    TAP_ZH,
    TAP_END
  } tap_t;

  typedef struct packed {
    logic       acc_clr;
    logic       acc_en;
    logic       acc_dbl;
    logic       prev_cap;
    logic       mul_n;
    logic       mul_p;
    logic [1:0] walls;
  } dp_ctl_t;

endpackage

// ===== sv/fdtd_room_reverb_top.sv =====
// fdtd room reverb, top level: three pressure banks, configuration registers, stream ports
// depends on frr_pkg, frr_ram, frr_ctrl, frr_dp and fdtd_room_reverb_top_defines.svh
//
// One input sample advances a cubic room of GRID_SIDE^3 cells by one time step of the
// wave equation and yields the pressure at the listener cell as one output sample.
// The three time levels live in three single-port-read rams that trade roles by a
// rotation counter, so no bank is ever copied. After reset a clearing pass writes zero
// to every cell, during which no sample is taken; configuration writes are taken at any
// time. A sample then sweeps every cell, after an injection read and write when the source
// cell is inside the grid: each cell reads its centre and six mirrored neighbours one per
// cycle through the read port of the current-level bank, then does the two weight
// multiplies and the write into the next-level bank. The result sits in an output
// register, so a stalled output does not hold off the next sample until the end of
// its sweep. Registers: face, edge and corner weights (Q2.16), source and listener
// flat indexes x + side*(y + side*z); an index beyond the grid disables injection
// or returns zero.
`include "fdtd_room_reverb_top_defines.svh"

module fdtd_room_reverb_top #(
  parameter int GRID_SIDE = 10,
  parameter int CELL_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  // input sample stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [23:0] sample_in
  // output sample stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [23:0] sample_out
  // register write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [17:0] cfg_data
);

  localparam int CELLS = GRID_SIDE ** 3;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = frr_pkg::COEF_W;

  // configuration registers
  logic signed [CW-1:0] coef_face_neighbor, coef_face_prev;
  logic signed [CW-1:0] coef_edge_neighbor, coef_edge_prev;
  logic signed [CW-1:0] coef_corner_neighbor, coef_corner_prev;
  logic [frr_pkg::IDX_W-1:0] source_cell, listener_cell;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_face_neighbor   <= frr_pkg::RST_FACE_NB;
      coef_face_prev       <= frr_pkg::RST_FACE_PV;
      coef_edge_neighbor   <= frr_pkg::RST_EDGE_NB;
      coef_edge_prev       <= frr_pkg::RST_EDGE_PV;
      coef_corner_neighbor <= frr_pkg::RST_CORNER_NB;
      coef_corner_prev     <= frr_pkg::RST_CORNER_PV;
      source_cell          <= frr_pkg::RST_SOURCE;
      listener_cell        <= frr_pkg::RST_LISTENER;
    end else if (cfg_valid && cfg_ready) begin
      // a transfer to an index beyond the list is dropped
      unique case (cfg_index)
        frr_pkg::REG_FACE_NB:   coef_face_neighbor   <= cfg_data;
        frr_pkg::REG_FACE_PV:   coef_face_prev       <= cfg_data;
        frr_pkg::REG_EDGE_NB:   coef_edge_neighbor   <= cfg_data;
        frr_pkg::REG_EDGE_PV:   coef_edge_prev       <= cfg_data;
        frr_pkg::REG_CORNER_NB: coef_corner_neighbor <= cfg_data;
        frr_pkg::REG_CORNER_PV: coef_corner_prev     <= cfg_data;
        frr_pkg::REG_SOURCE:    source_cell          <= cfg_data[frr_pkg::IDX_W-1:0];
        frr_pkg::REG_LISTENER:  listener_cell        <= cfg_data[frr_pkg::IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  logic             out_free, out_load, lst_ok, clearing, we_inj, we_next;
  logic [1:0]       rot;
  logic [AW-1:0]    now_raddr, prev_raddr, waddr;
  frr_pkg::dp_ctl_t dp_ctl;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  frr_ctrl #(.GRID_SIDE(GRID_SIDE)) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .source_cell   (source_cell),
    .listener_cell (listener_cell),
    .out_free      (out_free),
    .out_load      (out_load),
    .lst_ok        (lst_ok),
    .rot           (rot),
    .now_raddr     (now_raddr),
    .prev_raddr    (prev_raddr),
    .waddr         (waddr),
    .clearing      (clearing),
    .we_inj        (we_inj),
    .we_next       (we_next),
    .dp_ctl        (dp_ctl)
  );

  // sample held for the whole step, and the one before it
  logic signed [23:0] sample_r, prev_input;

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) sample_r <= s_axis_tdata;
  end

  always_ff @(posedge clk) begin
    if (rst) prev_input <= '0;
    else if (out_load) prev_input <= sample_r;
  end

  // banks: now = rot, next = rot+1, prev = rot+2 (mod 3)
  logic [CELL_BITS-1:0] rdata [3];
  logic [CELL_BITS-1:0] now_rdata, prev_rdata, cell_res, inj_now, inj_prev;
  logic [2:0]           bank_we;

  for (genvar b = 0; b < 3; b++) begin : g_bank
    logic                 is_now, is_next;
    logic [AW-1:0]        raddr;
    logic [CELL_BITS-1:0] wdata;

    assign is_now  = (rot == 2'(b));
    assign is_next = (rot == 2'((b + 2) % 3));
    assign raddr   = is_now ? now_raddr : prev_raddr;
    assign bank_we[b] = clearing || (is_next ? we_next : we_inj);

    always_comb begin
      if (clearing)     wdata = '0;
      else if (is_next) wdata = cell_res;
      else if (is_now)  wdata = inj_now;
      else              wdata = inj_prev;
    end

    frr_ram #(.WIDTH(CELL_BITS), .DEPTH(CELLS)) u_ram (
      .clk   (clk),
      .we    (bank_we[b]),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata[b])
    );
  end

  always_comb begin
    unique case (rot)
      2'd0:    begin now_rdata = rdata[0]; prev_rdata = rdata[2]; end
      2'd1:    begin now_rdata = rdata[1]; prev_rdata = rdata[0]; end
      default: begin now_rdata = rdata[2]; prev_rdata = rdata[1]; end
    endcase
  end

  frr_dp #(.CELL_BITS(CELL_BITS)) u_dp (
    .clk                  (clk),
    .ctl                  (dp_ctl),
    .coef_face_neighbor   (coef_face_neighbor),
    .coef_face_prev       (coef_face_prev),
    .coef_edge_neighbor   (coef_edge_neighbor),
    .coef_edge_prev       (coef_edge_prev),
    .coef_corner_neighbor (coef_corner_neighbor),
    .coef_corner_prev     (coef_corner_prev),
    .now_rdata            (now_rdata),
    .prev_rdata           (prev_rdata),
    .sample               (sample_r),
    .prev_sample          (prev_input),
    .cell_res             (cell_res),
    .inj_now              (inj_now),
    .inj_prev             (inj_prev)
  );

  // listener readout, clamped to Q1.23
  logic [CELL_BITS-24:0] lst_top;
  logic [23:0]           lst_val;

  assign lst_top = now_rdata[CELL_BITS-1:23];
  always_comb begin
    if (!lst_ok)                        lst_val = '0;
    else if ((&lst_top) || !(|lst_top)) lst_val = now_rdata[23:0];
    else if (now_rdata[CELL_BITS-1])    lst_val = 24'h800000;
    else                                lst_val = 24'h7FFFFF;
  end

  // output register parts the result from the sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) m_axis_tdata <= lst_val;
  end

  // checks
  `FRR_ASSERT_NOW(a_no_take_in_clear, clearing, !s_axis_tready, "sample taken while clearing")
  `FRR_ASSERT_NOW(a_inj_not_sweep, we_inj, !we_next && !clearing, "injection overlaps a sweep")
  `FRR_ASSERT_NEXT(a_busy_after_take, s_axis_tvalid && s_axis_tready, !s_axis_tready,
                   "second sample taken during a step")
  `FRR_ASSERT_NOW(a_load_when_free, out_load, out_free, "pending result overwritten")

endmodule

// ===== sv/frr_ram.sv =====
// generic single-clock ram, one write port, one registered read port
// no dependencies
module frr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/frr_ctrl.sv =====
// sequencer of the fdtd room reverb: clearing pass, injection, cell sweep, readout
// depends on frr_pkg
module frr_ctrl #(
  parameter int GRID_SIDE = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [frr_pkg::IDX_W-1:0]    source_cell,
  input  logic [frr_pkg::IDX_W-1:0]    listener_cell,
  input  logic                         out_free,
  output logic                         out_load,
  output logic                         lst_ok,
  output logic [1:0]                   rot,
  output logic [$clog2(GRID_SIDE**3)-1:0] now_raddr,
  output logic [$clog2(GRID_SIDE**3)-1:0] prev_raddr,
  output logic [$clog2(GRID_SIDE**3)-1:0] waddr,
  output logic                         clearing,
  output logic                         we_inj,
  output logic                         we_next,
  output frr_pkg::dp_ctl_t             dp_ctl
);

  localparam int CELLS = GRID_SIDE ** 3;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(GRID_SIDE);
  localparam logic [AW-1:0] ONE  = AW'(1);
  localparam logic [AW-1:0] STY  = AW'(GRID_SIDE);
  localparam logic [AW-1:0] STZ  = AW'(GRID_SIDE * GRID_SIDE);
  localparam logic [AW-1:0] LAST = AW'(CELLS - 1);
  localparam logic [CW-1:0] EDGE = CW'(GRID_SIDE - 1);

  frr_pkg::state_t state, state_next;
  frr_pkg::tap_t   tap;
  logic [AW-1:0]   clr_addr;
  logic [AW-1:0]   idx;
  logic [CW-1:0]   x, y, z;
  logic            src_ok;
  logic            wx, wy, wz;
  logic [AW-1:0]   src_a, lst_a, nbr_a;

  assign src_ok = 32'(source_cell) < 32'(CELLS);
  assign lst_ok = 32'(listener_cell) < 32'(CELLS);
  assign src_a  = AW'(source_cell);
  assign lst_a  = AW'(listener_cell);
  assign wx = (x == '0) || (x == EDGE);
  assign wy = (y == '0) || (y == EDGE);
  assign wz = (z == '0) || (z == EDGE);

  // mirrored neighbour address: step inward when on the wall
  always_comb begin
    unique case (tap)
      frr_pkg::TAP_C:  nbr_a = idx;
      frr_pkg::TAP_XL: nbr_a = (x == '0)  ? idx + ONE : idx - ONE;
      frr_pkg::TAP_XH: nbr_a = (x == EDGE) ? idx - ONE : idx + ONE;
      frr_pkg::TAP_YL: nbr_a = (y == '0)  ? idx + STY : idx - STY;
      frr_pkg::TAP_YH: nbr_a = (y == EDGE) ? idx - STY : idx + STY;
      frr_pkg::TAP_ZL: nbr_a = (z == '0)  ? idx + STZ : idx - STZ;
      frr_pkg::TAP_ZH: nbr_a = (z == EDGE) ? idx - STZ : idx + STZ;
      default:         nbr_a = idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= frr_pkg::ST_CLEAR;
      clr_addr <= '0;
      idx      <= '0;
      x        <= '0;
      y        <= '0;
      z        <= '0;
      tap      <= frr_pkg::TAP_C;
      rot      <= 2'd0;
    end else begin
      state <= state_next;
      if (state == frr_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + ONE;
      end
      if (state == frr_pkg::ST_READ) begin
        tap <= frr_pkg::tap_t'(tap + 3'd1);
      end
      if (state == frr_pkg::ST_WRITE) begin
        tap <= frr_pkg::TAP_C;
        if (idx == LAST) begin
          idx <= '0;
          x   <= '0;
          y   <= '0;
          z   <= '0;
          rot <= (rot == 2'd2) ? 2'd0 : rot + 2'd1;
        end else begin
          idx <= idx + ONE;
          if (x == EDGE) begin
            x <= '0;
            if (y == EDGE) begin
              y <= '0;
              z <= z + CW'(1);
            end else begin
              y <= y + CW'(1);
            end
          end else begin
            x <= x + CW'(1);
          end
        end
      end
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    clearing   = 1'b0;
    we_inj     = 1'b0;
    we_next    = 1'b0;
    now_raddr  = lst_a;
    prev_raddr = idx;
    waddr      = idx;
    dp_ctl     = '0;
    dp_ctl.walls = 2'(wx) + 2'(wy) + 2'(wz);
    unique case (state)
      frr_pkg::ST_CLEAR: begin
        clearing = 1'b1;
        waddr    = clr_addr;
        if (clr_addr == LAST) state_next = frr_pkg::ST_IDLE;
      end
      frr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = src_ok ? frr_pkg::ST_INJ_RD : frr_pkg::ST_READ;
      end
      frr_pkg::ST_INJ_RD: begin
        now_raddr  = src_a;
        prev_raddr = src_a;
        state_next = frr_pkg::ST_INJ_WR;
      end
      frr_pkg::ST_INJ_WR: begin
        waddr      = src_a;
        we_inj     = 1'b1;
        state_next = frr_pkg::ST_READ;
      end
      frr_pkg::ST_READ: begin
        now_raddr       = nbr_a;
        dp_ctl.acc_clr  = (tap == frr_pkg::TAP_C);
        dp_ctl.acc_en   = (tap != frr_pkg::TAP_C);
        dp_ctl.acc_dbl  = (tap == frr_pkg::TAP_XL);
        dp_ctl.prev_cap = (tap == frr_pkg::TAP_XL);
        if (tap == frr_pkg::TAP_END) state_next = frr_pkg::ST_MUL_N;
      end
      frr_pkg::ST_MUL_N: begin
        dp_ctl.mul_n = 1'b1;
        state_next   = frr_pkg::ST_MUL_P;
      end
      frr_pkg::ST_MUL_P: begin
        dp_ctl.mul_p = 1'b1;
        state_next   = frr_pkg::ST_WRITE;
      end
      frr_pkg::ST_WRITE: begin
        we_next    = 1'b1;
        state_next = (idx == LAST) ? frr_pkg::ST_OUT_RD : frr_pkg::ST_READ;
      end
      frr_pkg::ST_OUT_RD: begin
        state_next = frr_pkg::ST_OUT_LOAD;
      end
      frr_pkg::ST_OUT_LOAD: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = frr_pkg::ST_IDLE;
        end
      end
      default: state_next = frr_pkg::ST_CLEAR;
    endcase
  end

endmodule

// ===== sv/frr_dp.sv =====
// arithmetic of the fdtd room reverb: stencil sum, weighting, rounding, saturation
// depends on frr_pkg
module frr_dp #(
  parameter int CELL_BITS = 32
) (
  input  logic                                 clk,
  input  frr_pkg::dp_ctl_t                     ctl,
  input  logic signed [frr_pkg::COEF_W-1:0]    coef_face_neighbor,
  input  logic signed [frr_pkg::COEF_W-1:0]    coef_face_prev,
  input  logic signed [frr_pkg::COEF_W-1:0]    coef_edge_neighbor,
  input  logic signed [frr_pkg::COEF_W-1:0]    coef_edge_prev,
  input  logic signed [frr_pkg::COEF_W-1:0]    coef_corner_neighbor,
  input  logic signed [frr_pkg::COEF_W-1:0]    coef_corner_prev,
  input  logic [CELL_BITS-1:0]                 now_rdata,
  input  logic [CELL_BITS-1:0]                 prev_rdata,
  input  logic signed [frr_pkg::SMP_W-1:0]     sample,
  input  logic signed [frr_pkg::SMP_W-1:0]     prev_sample,
  output logic [CELL_BITS-1:0]                 cell_res,
  output logic [CELL_BITS-1:0]                 inj_now,
  output logic [CELL_BITS-1:0]                 inj_prev
);

  localparam int SUM_W  = CELL_BITS + 3;
  localparam int PROD_W = SUM_W + frr_pkg::COEF_W;
  localparam int DIFF_W = PROD_W + 1;
  localparam int TOP_W  = DIFF_W - CELL_BITS + 1;
  localparam logic [DIFF_W-1:0]    RND    = DIFF_W'(32768);
  localparam logic [CELL_BITS-1:0] C_MAX  = {1'b0, {(CELL_BITS-1){1'b1}}};
  localparam logic [CELL_BITS-1:0] C_MIN  = {1'b1, {(CELL_BITS-1){1'b0}}};

  logic signed [SUM_W-1:0]           acc;
  logic signed [CELL_BITS-1:0]       prev_r;
  logic signed [PROD_W-1:0]          pn, pp;
  logic signed [frr_pkg::COEF_W-1:0] cn, cp;
  logic signed [SUM_W-1:0]           d_one, d_two;
  logic signed [DIFF_W-1:0]          diff, q;
  logic [TOP_W-1:0]                  top;
  logic [CELL_BITS:0]                s_now, s_prev;

  always_comb begin
    unique case (ctl.walls)
      2'd0: begin cn = frr_pkg::INT_NB;       cp = frr_pkg::INT_PV;       end
      2'd1: begin cn = coef_face_neighbor;    cp = coef_face_prev;        end
      2'd2: begin cn = coef_edge_neighbor;    cp = coef_edge_prev;        end
      default: begin cn = coef_corner_neighbor; cp = coef_corner_prev;    end
    endcase
  end

  assign d_one = {{3{now_rdata[CELL_BITS-1]}}, now_rdata};
  assign d_two = {{2{now_rdata[CELL_BITS-1]}}, now_rdata, 1'b0};

  always_ff @(posedge clk) begin
    if (ctl.acc_clr) begin
      acc <= '0;
    end else if (ctl.acc_en) begin
      acc <= acc + (ctl.acc_dbl ? d_two : d_one);
    end
    if (ctl.prev_cap) prev_r <= prev_rdata;
    if (ctl.mul_n)    pn <= cn * acc;
    if (ctl.mul_p)    pp <= cp * prev_r;
  end

  // round half up, floor shift by 16, clamp to the cell range
  assign diff = {pn[PROD_W-1], pn} - {pp[PROD_W-1], pp} + RND;
  assign q    = diff >>> 16;
  assign top  = q[DIFF_W-1:CELL_BITS-1];
  always_comb begin
    if ((&top) || !(|top)) cell_res = q[CELL_BITS-1:0];
    else                   cell_res = q[DIFF_W-1] ? C_MIN : C_MAX;
  end

  // source injection into the current and previous levels
  assign s_now  = {now_rdata[CELL_BITS-1], now_rdata}
                + (CELL_BITS+1)'(sample);
  assign s_prev = {prev_rdata[CELL_BITS-1], prev_rdata}
                + (CELL_BITS+1)'(prev_sample);
  always_comb begin
    if (s_now[CELL_BITS] == s_now[CELL_BITS-1]) inj_now = s_now[CELL_BITS-1:0];
    else inj_now = s_now[CELL_BITS] ? C_MIN : C_MAX;
    if (s_prev[CELL_BITS] == s_prev[CELL_BITS-1]) inj_prev = s_prev[CELL_BITS-1:0];
    else inj_prev = s_prev[CELL_BITS] ? C_MIN : C_MAX;
  end

endmodule

// ===== test/frr_checker.sv =====
`timescale 1ns / 100ps
// predictor and scoreboard for the fdtd room reverb block
// watches the sample, result and register channels; depends on frr_pkg
module frr_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [17:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          results_seen
);

  localparam int SIDE  = 10;
  localparam int CELLS = SIDE * SIDE * SIDE;
  localparam longint CELL_HI = 64'sd2147483647;
  localparam longint CELL_LO = -64'sd2147483648;

  longint room_now  [CELLS];
  longint room_prev [CELLS];
  longint room_next [CELLS];
  longint last_sample;
  logic signed [frr_pkg::COEF_W-1:0] face_nb, face_pv, edge_nb, edge_pv, corner_nb, corner_pv;
  logic [frr_pkg::IDX_W-1:0] source_idx, listener_idx;
  logic [23:0] listener_q [$];

  function automatic longint clip_cell(input longint v);
    if (v > CELL_HI) return CELL_HI;
    if (v < CELL_LO) return CELL_LO;
    return v;
  endfunction

  function automatic int mirror_lo(input int c);
    return (c == 0) ? 1 : c - 1;
  endfunction

  function automatic int mirror_hi(input int c);
    return (c == SIDE - 1) ? c - 1 : c + 1;
  endfunction

  function automatic int cell_at(input int x, input int y, input int z);
    return x + SIDE * (y + SIDE * z);
  endfunction

  // one time step of the room; returns the listener pressure
  function automatic logic [23:0] advance_room(input logic signed [23:0] smp);
    longint s, cn, cp, res;
    int i, walls;
    if (source_idx < CELLS) begin
      room_now[source_idx]  = clip_cell(room_now[source_idx] + longint'(smp));
      room_prev[source_idx] = clip_cell(room_prev[source_idx] + last_sample);
    end
    for (int z = 0; z < SIDE; z++)
      for (int y = 0; y < SIDE; y++)
        for (int x = 0; x < SIDE; x++) begin
          i = cell_at(x, y, z);
          walls = int'(x == 0 || x == SIDE - 1) + int'(y == 0 || y == SIDE - 1)
                + int'(z == 0 || z == SIDE - 1);
          s = room_now[cell_at(mirror_lo(x), y, z)] + room_now[cell_at(mirror_hi(x), y, z)]
            + room_now[cell_at(x, mirror_lo(y), z)] + room_now[cell_at(x, mirror_hi(y), z)]
            + room_now[cell_at(x, y, mirror_lo(z))] + room_now[cell_at(x, y, mirror_hi(z))]
            + 2 * room_now[i];
          case (walls)
            0: begin cn = longint'(frr_pkg::INT_NB); cp = longint'(frr_pkg::INT_PV); end
            1: begin cn = longint'(face_nb); cp = longint'(face_pv); end
            2: begin cn = longint'(edge_nb); cp = longint'(edge_pv); end
            default: begin cn = longint'(corner_nb); cp = longint'(corner_pv); end
          endcase
          // products stay far below 2^62, so an arithmetic shift is the floor
          room_next[i] = clip_cell((cn * s - cp * room_prev[i] + 32768) >>> 16);
        end
    room_prev = room_now;
    room_now  = room_next;
    last_sample = longint'(smp);
    res = 0;
    if (listener_idx < CELLS) begin
      res = room_now[listener_idx];
      if (res > 8388607) res = 8388607;
      if (res < -8388608) res = -8388608;
    end
    return res[23:0];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CELLS; i++) begin
        room_now[i] = 0;
        room_prev[i] = 0;
        room_next[i] = 0;
      end
      last_sample = 0;
      face_nb = frr_pkg::RST_FACE_NB;     face_pv = frr_pkg::RST_FACE_PV;
      edge_nb = frr_pkg::RST_EDGE_NB;     edge_pv = frr_pkg::RST_EDGE_PV;
      corner_nb = frr_pkg::RST_CORNER_NB; corner_pv = frr_pkg::RST_CORNER_PV;
      source_idx = frr_pkg::RST_SOURCE;   listener_idx = frr_pkg::RST_LISTENER;
      listener_q.delete();
      fail_count = 0;
      results_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          frr_pkg::REG_FACE_NB:   face_nb = cfg_data;
          frr_pkg::REG_FACE_PV:   face_pv = cfg_data;
          frr_pkg::REG_EDGE_NB:   edge_nb = cfg_data;
          frr_pkg::REG_EDGE_PV:   edge_pv = cfg_data;
          frr_pkg::REG_CORNER_NB: corner_nb = cfg_data;
          frr_pkg::REG_CORNER_PV: corner_pv = cfg_data;
          frr_pkg::REG_SOURCE:    source_idx = cfg_data[frr_pkg::IDX_W-1:0];
          frr_pkg::REG_LISTENER:  listener_idx = cfg_data[frr_pkg::IDX_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        listener_q = {listener_q, advance_room(s_axis_tdata)};
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (listener_q.size() == 0) begin
          $error("unexpected result transfer, sample_out %h", m_axis_tdata);
          fail_count++;
        end else if (m_axis_tdata !== listener_q[0]) begin
          $error("sample_out expected %h actual %h", listener_q[0], m_axis_tdata);
          fail_count++;
          void'(listener_q.pop_front());
        end else begin
          void'(listener_q.pop_front());
        end
      end
    end
    pending = listener_q.size();
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// stimulus and verdict for the fdtd room reverb block
// depends on frr_pkg, frr_checker and the block's rtl
module tb_top;

  // 560 steps plus stalls fit well inside this cycle limit
  localparam longint CYCLE_LIMIT = 40_000_000;
  // register indexes past the end of the list
  localparam logic [7:0] IDX_PAST_LIST = 8'd8;
  localparam logic [7:0] IDX_FAR_PAST  = 8'd255;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [17:0] cfg_data = '0;

  int fail_count, pending, results_seen;
  int send_idle_pct = 0;   // percent of cycles the sample side holds back
  int recv_idle_pct = 0;   // percent of cycles the result side drops tready
  int hold_cycles = 0;     // long result-side stall still to run
  bit stall_req = 1'b0;    // raised by the stimulus to ask for a long stall
  bit stall_ack = 1'b0;
  int samples_sent = 0;
  longint cycles = 0;

  always #2 clk = ~clk;

  fdtd_room_reverb_top uut (.*);

  frr_checker chk (.*);

  // result side: random drops of tready, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_req != stall_ack) begin
      stall_ack <= stall_req;
      hold_cycles <= 40000;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !rst && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // one sample transfer; tvalid stays up between back-to-back samples
  task automatic send_sample(input logic [23:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= v;
    do @(posedge clk); while (!s_axis_tready);
    samples_sent++;
  endtask

  // register writes only happen with the block idle
  task automatic write_reg(input logic [7:0] idx, input logic [17:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_weights(input logic [17:0] val);
    write_reg(frr_pkg::REG_FACE_NB, val);
    write_reg(frr_pkg::REG_FACE_PV, val);
    write_reg(frr_pkg::REG_EDGE_NB, val);
    write_reg(frr_pkg::REG_EDGE_PV, val);
    write_reg(frr_pkg::REG_CORNER_NB, val);
    write_reg(frr_pkg::REG_CORNER_PV, val);
  endtask

  // wait until every expected result is back, then let the block settle
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [23:0] rand_sample;
    case ($urandom_range(7))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic run_random(input int n);
    for (int k = 0; k < n; k++) send_sample(rand_sample());
  endtask

  task automatic random_config;
    write_reg(frr_pkg::REG_FACE_NB, 18'($urandom));
    write_reg(frr_pkg::REG_FACE_PV, 18'($urandom));
    write_reg(frr_pkg::REG_EDGE_NB, 18'($urandom));
    write_reg(frr_pkg::REG_EDGE_PV, 18'($urandom));
    write_reg(frr_pkg::REG_CORNER_NB, 18'($urandom));
    write_reg(frr_pkg::REG_CORNER_PV, 18'($urandom));
    // mostly inside the grid, sometimes beyond it
    write_reg(frr_pkg::REG_SOURCE, ($urandom_range(9) == 0) ? 18'($urandom_range(1023, 1000))
                                                            : 18'($urandom_range(999)));
    write_reg(frr_pkg::REG_LISTENER, ($urandom_range(9) == 0) ? 18'($urandom_range(1023, 1000))
                                                              : 18'($urandom_range(999)));
  endtask

  initial begin
    logic [23:0] corner_vals [8];
    corner_vals = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF,
                    24'h000001, 24'h555555, 24'hAAAAAA, 24'h7FFFFF};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: reset weights and taps, field extremes and bit patterns
    send_idle_pct = 32; recv_idle_pct = 86;
    foreach (corner_vals[i]) send_sample(corner_vals[i]);
    repeat (12) send_sample(24'h7FFFFF);
    drain();

    // random weights and a random listener; an index past the list is ignored
    random_config();
    write_reg(IDX_PAST_LIST, 18'h3FFFF);
    write_reg(IDX_FAR_PAST, 18'h15555);
    write_reg(frr_pkg::REG_LISTENER, 18'($urandom_range(999)));
    // long result-side stall while samples keep coming, so input backs up
    stall_req = 1'b1;
    run_random(180);
    drain();

    // extremes: largest weights with full-scale drive saturates the cells
    send_idle_pct = 86; recv_idle_pct = 32;
    write_weights(18'h1FFFF);
    write_reg(frr_pkg::REG_SOURCE, 18'd0);
    write_reg(frr_pkg::REG_LISTENER, 18'd1);
    repeat (40) send_sample(24'h7FFFFF);
    run_random(20);
    drain();
    // most negative weights, listener beyond the grid reads zero
    write_weights(18'h20000);
    write_reg(frr_pkg::REG_SOURCE, 18'd999);
    write_reg(frr_pkg::REG_LISTENER, 18'd1023);
    run_random(60);
    drain();
    // source beyond the grid injects nothing
    write_reg(frr_pkg::REG_SOURCE, 18'd1000);
    write_reg(frr_pkg::REG_LISTENER, 18'd998);
    run_random(60);
    drain();

    // free-running, fresh random setup
    send_idle_pct = 0; recv_idle_pct = 0;
    random_config();
    run_random(180);
    drain();

    $display("covered %0d samples and %0d checked results over reset, random and extreme",
             samples_sent, results_seen);
    $display("settings, including out-of-grid source and listener taps");
    if (fail_count == 0 && results_seen == samples_sent)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule
